### design/ssse3_pkg.sv
package ssse3_pkg;

    typedef enum logic [3:0] {
        F_SIGNB  = 4'd0,
        F_SIGNW  = 4'd1,
        F_SIGND  = 4'd2,
        F_ABSB   = 4'd3,
        F_ABSW   = 4'd4,
        F_ABSD   = 4'd5,
        F_ALIGN  = 4'd6,
        F_SHUF   = 4'd7,
        F_MULHRS = 4'd8,
        F_MADDUB = 4'd9,
        F_HSUBW  = 4'd10,
        F_HSUBD  = 4'd11,
        F_HSUBSW = 4'd12,
        F_HADDW  = 4'd13,
        F_HADDD  = 4'd14,
        F_HADDSW = 4'd15
    } t_func;

    typedef struct packed {
        logic [3:0]  func;
        logic        narrow_mode;
        logic [63:0] dest_low;
        logic [63:0] dest_high;
        logic [63:0] source_low;
        logic [63:0] source_high;
        logic [7:0]  shift_bytes;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
    } t_out_beat;

    localparam int NUM_WORDS = 8;

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7fff;
        end else if (v < -18'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### design/ssse3_lane.sv
module ssse3_lane (
    input  logic [3:0]  i_func,
    input  logic [15:0] i_d,
    input  logic [15:0] i_s,
    input  logic [15:0] i_ha,
    input  logic [15:0] i_hb,
    input  logic [15:0] i_hc,
    input  logic [15:0] i_hd,
    input  logic        i_dword_hi,
    output logic [15:0] o_r
);
    import ssse3_pkg::*;

    logic signed [31:0] prod;
    logic [31:0]        rnd;
    logic signed [16:0] m0, m1;
    logic signed [17:0] msum;
    logic [15:0]        absw, absb0, absb1;
    logic [15:0]        sgnw, sgnb0, sgnb1;
    logic [31:0]        dw_add, dw_sub;
    logic signed [17:0] sadd, ssub;

    always_comb begin
        prod  = $signed(i_d) * $signed(i_s);
        rnd   = prod + 32'h4000;
        m0    = $signed({9'd0, i_d[7:0]}) * $signed({{9{i_s[7]}}, i_s[7:0]});
        m1    = $signed({9'd0, i_d[15:8]}) * $signed({{9{i_s[15]}}, i_s[15:8]});
        msum  = 18'(m0) + 18'(m1);
        absw  = i_s[15] ? 16'(-i_s) : i_s;
        absb0 = {8'd0, i_s[7] ? 8'(-i_s[7:0]) : i_s[7:0]};
        absb1 = {8'd0, i_s[15] ? 8'(-i_s[15:8]) : i_s[15:8]};
        sgnw  = i_s[15] ? 16'(-i_d) : ((i_s == 16'd0) ? 16'd0 : i_d);
        sgnb0 = {8'd0, i_s[7] ? 8'(-i_d[7:0]) : ((i_s[7:0] == 8'd0) ? 8'd0 : i_d[7:0])};
        sgnb1 = {8'd0, i_s[15] ? 8'(-i_d[15:8])
                               : ((i_s[15:8] == 8'd0) ? 8'd0 : i_d[15:8])};
        dw_add = {i_hb, i_ha} + {i_hd, i_hc};
        dw_sub = {i_hb, i_ha} - {i_hd, i_hc};
        sadd  = 18'($signed(i_ha)) + 18'($signed(i_hb));
        ssub  = 18'($signed(i_ha)) - 18'($signed(i_hb));
        case (t_func'(i_func))
            F_SIGNB:  o_r = {sgnb1[7:0], sgnb0[7:0]};
            F_SIGNW:  o_r = sgnw;
            F_ABSB:   o_r = {absb1[7:0], absb0[7:0]};
            F_ABSW:   o_r = absw;
            F_MULHRS: o_r = rnd[30:15];
            F_MADDUB: o_r = sat16(msum);
            F_HSUBW:  o_r = 16'(i_ha - i_hb);
            F_HADDW:  o_r = 16'(i_ha + i_hb);
            F_HSUBSW: o_r = sat16(ssub);
            F_HADDSW: o_r = sat16(sadd);
            F_HSUBD:  o_r = i_dword_hi ? dw_sub[31:16] : dw_sub[15:0];
            F_HADDD:  o_r = i_dword_hi ? dw_add[31:16] : dw_add[15:0];
            default:  o_r = 16'd0;
        endcase
    end
endmodule

### design/ssse3_merge.sv
module ssse3_merge (
    input  logic [3:0]   i_func,
    input  logic         i_narrow,
    input  logic [127:0] i_d,
    input  logic [127:0] i_s,
    input  logic [7:0]   i_imm,
    input  logic [127:0] i_lanes,
    output logic [127:0] o_r
);
    import ssse3_pkg::*;

    logic [255:0] cat;
    logic [8:0]   pos;
    logic [127:0] alg, shf, dsd, res;
    logic [31:0]  dv, sv, rv;
    logic [3:0]   idx;

    always_comb begin
        cat = i_narrow ? {128'd0, i_d[63:0], i_s[63:0]} : {i_d, i_s};
        for (int i = 0; i < 16; i++) begin
            pos = 9'(i_imm) + 9'(i);
            alg[8*i +: 8] = (pos < (i_narrow ? 9'd16 : 9'd32)) ? cat[8*pos[4:0] +: 8] : 8'd0;
            idx = i_narrow ? {1'b0, i_s[8*i +: 3]} : i_s[8*i +: 4];
            shf[8*i +: 8] = i_s[8*i+7] ? 8'd0 : i_d[8*idx +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            dv = i_d[32*i +: 32];
            sv = i_s[32*i +: 32];
            if (i_func == F_SIGND) begin
                rv = sv[31] ? 32'(-dv) : ((sv == 32'd0) ? 32'd0 : dv);
            end else begin
                rv = sv[31] ? 32'(-sv) : sv;
            end
            dsd[32*i +: 32] = rv;
        end
        case (t_func'(i_func))
            F_ALIGN:         res = alg;
            F_SHUF:          res = shf;
            F_SIGND, F_ABSD: res = dsd;
            default:         res = i_lanes;
        endcase
        o_r = i_narrow ? {64'd0, res[63:0]} : res;
    end
endmodule

### design/ssse3_packed_integer_alu_unit.sv
// packed-integer simd alu: one instruction per beat, one beat accepted every cycle while
// o_stall is low. eight 16-bit lanes compute the word and byte sign/abs, multiply and all
// horizontal operations in parallel; a merge stage adds align, shuffle and dword sign/abs
// and forms the result. the result sits in an output register backed by one skid entry:
// while the output is stalled one more beat is absorbed, then o_stall rises from a register.
module ssse3_packed_integer_alu_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  ssse3_pkg::t_in_beat   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output ssse3_pkg::t_out_beat  o_data
);
    import ssse3_pkg::*;

    logic [127:0] d, s, lanes, res;
    logic [255:0] h;
    logic         r_valid, r_skid_valid;
    logic [127:0] r_res, r_skid;
    logic         take;

    assign d = i_data.narrow_mode ? {64'd0, i_data.dest_low}
                                  : {i_data.dest_high, i_data.dest_low};
    assign s = i_data.narrow_mode ? {64'd0, i_data.source_low}
                                  : {i_data.source_high, i_data.source_low};

    // horizontal pair sources: low result words from d, high from s
    always_comb begin
        h = '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (i_data.func == F_HSUBD || i_data.func == F_HADDD) begin
                if (i_data.narrow_mode) begin
                    h[32*i +: 32] = (i < 2) ? d[31:0] : ((i < 4) ? s[31:0] : 32'd0);
                end else begin
                    h[32*i +: 32] = (i < 4) ? d[32*(2*(i/2)) +: 32] : s[32*(2*((i-4)/2)) +: 32];
                end
            end else begin
                if (i_data.narrow_mode) begin
                    h[32*i +: 32] = (i < 2) ? d[32*i +: 32] : ((i < 4) ? s[32*(i-2) +: 32] : 32'd0);
                end else begin
                    h[32*i +: 32] = (i < 4) ? d[32*i +: 32] : s[32*(i-4) +: 32];
                end
            end
        end
    end

    logic [255:0] hd;
    always_comb begin
        hd = '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (i_data.narrow_mode) begin
                hd[32*i +: 32] = (i < 2) ? d[63:32] : ((i < 4) ? s[63:32] : 32'd0);
            end else begin
                hd[32*i +: 32] = (i < 4) ? d[64*(i/2)+32 +: 32] : s[64*((i-4)/2)+32 +: 32];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_WORDS; g++) begin : g_lane
            logic [15:0] ha, hb, hc, hdd;
            assign ha  = h[32*g +: 16];
            assign hb  = h[32*g+16 +: 16];
            assign hc  = hd[32*g +: 16];
            assign hdd = hd[32*g+16 +: 16];
            ssse3_lane u_lane (
                .i_func     (i_data.func),
                .i_d        (d[16*g +: 16]),
                .i_s        (s[16*g +: 16]),
                .i_ha       (ha),
                .i_hb       (hb),
                .i_hc       (hc),
                .i_hd       (hdd),
                .i_dword_hi (1'(g % 2)),
                .o_r        (lanes[16*g +: 16])
            );
        end
    endgenerate

    ssse3_merge u_merge (
        .i_func   (i_data.func),
        .i_narrow (i_data.narrow_mode),
        .i_d      (d),
        .i_s      (s),
        .i_imm    (i_data.shift_bytes),
        .i_lanes  (lanes),
        .o_r      (res)
    );

    assign o_stall = r_skid_valid;
    assign take    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_valid && i_stall) begin
                if (take) begin
                    r_skid_valid <= 1'b1;
                end
            end else begin
                r_valid      <= r_skid_valid || take;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_valid && i_stall) begin
            if (take) begin
                r_skid <= res;
            end
        end else begin
            r_res <= r_skid_valid ? r_skid : res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = '{result_low: r_res[63:0], result_high: r_res[127:64]};
endmodule

### design/ssse3_checker.sv
module ssse3_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input ssse3_pkg::t_in_beat  i_data,
    input ssse3_pkg::t_out_beat o_data
);
    import ssse3_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !(o_valid && i_stall) |=> o_valid)
        else $error("accepted beat not presented");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_narrow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.narrow_mode && !(o_valid && i_stall)
        |=> o_data.result_high == 64'd0)
        else $error("narrow result high not zero");
endmodule

bind ssse3_packed_integer_alu_unit ssse3_checker u_checker (.*);
